@@ hdl/dcct_pkg.sv @@
`default_nettype none
package dcct_pkg;

  localparam int MaxTrianglesDefault = 4096;
  localparam int CoordWidthDefault = 24;
  localparam int DistW = 23;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VIEWER_X      = 3'd0,
    REG_VIEWER_Y      = 3'd1,
    REG_VIEWER_Z      = 3'd2,
    REG_ADD_DISTANCE  = 3'd3,
    REG_SLOP_DISTANCE = 3'd4,
    REG_NUM_TRIANGLES = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_REMOVED  = 2'd1,
    ACT_INSERTED = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_X,
    PH_Y,
    PH_Z,
    PH_ADD,
    PH_REM,
    PH_FIN
  } phase_t;

  typedef struct packed {
    logic   accept;
    phase_t phase;
    logic   commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/dcct_ram.sv @@
`default_nettype none
module dcct_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr,
  input  wire logic [Width-1:0]                      wdata,
  output logic      [Width-1:0]                      rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ hdl/dcct_ctrl.sv @@
`default_nettype none
module dcct_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic                s_tuser,
  input  wire dcct_pkg::dp_status_t status,
  output dcct_pkg::ctrl_cmd_t      cmd
);
  import dcct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_X, S_Y, S_Z, S_ADD, S_REM, S_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid) state <= s_tuser ? S_X : S_FILL;
        S_FILL: if (status.fill_last) state <= S_FIN;
        S_X:    state <= S_Y;
        S_Y:    state <= S_Z;
        S_Z:    state <= S_ADD;
        S_ADD:  state <= S_REM;
        S_REM:  state <= S_FIN;
        S_FIN:  if (!status.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.accept = s_tvalid && s_tready;
    cmd.commit = (state == S_FIN) && !status.out_busy;
    unique case (state)
      S_IDLE:  cmd.phase = PH_IDLE;
      S_FILL:  cmd.phase = PH_FILL;
      S_X:     cmd.phase = PH_X;
      S_Y:     cmd.phase = PH_Y;
      S_Z:     cmd.phase = PH_Z;
      S_ADD:   cmd.phase = PH_ADD;
      S_REM:   cmd.phase = PH_REM;
      S_FIN:   cmd.phase = PH_FIN;
      default: cmd.phase = PH_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/dcct_dp.sv @@
`default_nettype none
module dcct_dp #(
  parameter int MaxTriangles = dcct_pkg::MaxTrianglesDefault,
  parameter int CoordWidth   = dcct_pkg::CoordWidthDefault,
  parameter int InW          = ((3 * CoordWidth + 7) / 8) * 8,
  parameter int IdxW         = (MaxTriangles > 1) ? $clog2(MaxTriangles) : 1,
  parameter int CntW         = $clog2(MaxTriangles + 1),
  parameter int OutW         = ((4 * IdxW + 3 + CntW + 7) / 8) * 8,
  parameter int CfgW         = (CoordWidth > CntW) ?
                               ((CoordWidth > dcct_pkg::DistW) ? CoordWidth : dcct_pkg::DistW) :
                               ((CntW > dcct_pkg::DistW) ? CntW : dcct_pkg::DistW)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dcct_pkg::ctrl_cmd_t           cmd,
  output dcct_pkg::dp_status_t               status,
  input  wire logic [InW-1:0]                s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [OutW-1:0]               m_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dcct_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]               cfg_data
);
  import dcct_pkg::*;

  localparam int MulW = (CoordWidth + 1 > DistW + 1) ? CoordWidth + 1 : DistW + 1;
  localparam int SumW = 2 * MulW + 2;
  localparam int PackW = 4 * IdxW + 3 + CntW;

  logic signed [CoordWidth-1:0] vx, vy, vz, cx, cy, cz;
  logic [DistW-1:0] add_d, slop_d;
  logic [CntW-1:0] num_tri;

  logic [CntW-1:0] n_eff, n_next;
  logic [CntW-1:0] live_total, cursor;
  logic [IdxW-1:0] id, fill_cnt, slot_r, tri_r, src_r;
  logic is_init;
  logic [2*MulW-1:0] prod;
  logic [SumW-1:0] dist_sum, add2;
  logic [MulW-1:0] mul_op;

  logic            a_we, b_we;
  logic [IdxW-1:0] a_addr, b_addr, a_wdata, b_wdata, a_rdata, b_rdata;

  logic            live, do_remove, do_insert, do_copy;
  logic [IdxW-1:0] last_slot;
  logic [CntW-1:0] id_inc;
  logic [PackW-1:0] pack;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= '0;
      vy <= '0;
      vz <= '0;
      add_d <= '0;
      slop_d <= '0;
      num_tri <= CntW'(MaxTriangles);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VIEWER_X:      vx <= cfg_data[CoordWidth-1:0];
        REG_VIEWER_Y:      vy <= cfg_data[CoordWidth-1:0];
        REG_VIEWER_Z:      vz <= cfg_data[CoordWidth-1:0];
        REG_ADD_DISTANCE:  add_d <= cfg_data[DistW-1:0];
        REG_SLOP_DISTANCE: slop_d <= cfg_data[DistW-1:0];
        REG_NUM_TRIANGLES: num_tri <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_tri == '0) begin
      n_next = CntW'(1);
    end else if (num_tri > CntW'(MaxTriangles)) begin
      n_next = CntW'(MaxTriangles);
    end else begin
      n_next = num_tri;
    end
  end

  function automatic logic [MulW-1:0] abs_diff(input logic signed [CoordWidth-1:0] a,
                                                input logic signed [CoordWidth-1:0] b);
    logic signed [CoordWidth:0] d;
    d = {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
    if (d[CoordWidth]) begin
      d = -d;
    end
    return MulW'(unsigned'(d));
  endfunction

  always_comb begin
    unique case (cmd.phase)
      PH_X:    mul_op = abs_diff(cx, vx);
      PH_Y:    mul_op = abs_diff(cy, vy);
      PH_Z:    mul_op = abs_diff(cz, vz);
      PH_ADD:  mul_op = MulW'(add_d);
      PH_REM:  mul_op = MulW'({1'b0, add_d} + {1'b0, slop_d});
      default: mul_op = '0;
    endcase
  end

  assign last_slot = IdxW'(live_total - CntW'(1));
  assign live = (CntW'(slot_r) < live_total) && (tri_r == id);
  assign do_remove = !is_init && live && (dist_sum > SumW'(prod)) && (live_total != '0);
  assign do_insert = !is_init && !live && (dist_sum < add2) &&
                     (live_total < CntW'(MaxTriangles));
  assign do_copy = do_insert || (do_remove && (slot_r != last_slot));
  assign id_inc = CntW'(id) + CntW'(1);

  always_comb begin
    a_we = 1'b0;
    b_we = 1'b0;
    a_addr = id;
    b_addr = a_rdata;
    a_wdata = fill_cnt;
    b_wdata = fill_cnt;
    unique case (cmd.phase)
      PH_FILL: begin
        a_we = 1'b1;
        b_we = 1'b1;
        a_addr = fill_cnt;
        b_addr = fill_cnt;
      end
      PH_Z: b_addr = last_slot;
      PH_FIN: begin
        if (do_remove && do_copy) begin
          a_we = cmd.commit;
          b_we = cmd.commit;
          a_addr = src_r;
          a_wdata = slot_r;
          b_addr = slot_r;
          b_wdata = src_r;
        end else if (do_insert) begin
          a_we = cmd.commit;
          b_we = cmd.commit;
          a_addr = id;
          a_wdata = IdxW'(live_total);
          b_addr = IdxW'(live_total);
          b_wdata = id;
        end
      end
      default: ;
    endcase
  end

  dcct_ram #(.Width(IdxW), .Depth(MaxTriangles)) u_slot_ram (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rdata)
  );

  dcct_ram #(.Width(IdxW), .Depth(MaxTriangles)) u_tri_ram (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
  );

  // The removal threshold stays in prod while the result waits to be taken.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cx <= s_tdata[CoordWidth-1:0];
      cy <= s_tdata[2*CoordWidth-1:CoordWidth];
      cz <= s_tdata[3*CoordWidth-1:2*CoordWidth];
      n_eff <= n_next;
      id <= (cursor < n_next) ? IdxW'(cursor) : '0;
      fill_cnt <= '0;
    end else if (cmd.phase == PH_FILL) begin
      fill_cnt <= fill_cnt + IdxW'(1);
    end
    if (cmd.phase != PH_FIN) begin
      prod <= mul_op * mul_op;
    end
    unique case (cmd.phase)
      PH_Y: begin
        dist_sum <= SumW'(prod);
        slot_r <= a_rdata;
      end
      PH_Z: begin
        dist_sum <= dist_sum + SumW'(prod);
        tri_r <= b_rdata;
      end
      PH_ADD: begin
        dist_sum <= dist_sum + SumW'(prod);
        src_r <= b_rdata;
      end
      PH_REM: add2 <= SumW'(prod);
      default: ;
    endcase
  end

  assign status.fill_last = (fill_cnt == IdxW'(n_eff - CntW'(1)));
  assign status.out_busy = m_tvalid && !m_tready;

  always_comb begin
    pack = '0;
    pack[IdxW-1:0] = is_init ? '0 : id;
    pack[IdxW+1:IdxW] = is_init ? ACT_NONE : (do_remove ? ACT_REMOVED :
                        (do_insert ? ACT_INSERTED : ACT_NONE));
    pack[IdxW+2] = !is_init && do_copy;
    pack[2*IdxW+2:IdxW+3] = (is_init || !do_copy) ? '0 : (do_insert ? IdxW'(live_total) : slot_r);
    pack[3*IdxW+2:2*IdxW+3] = (is_init || !do_copy) ? '0 : (do_insert ? id : src_r);
    pack[3*IdxW+CntW+2:3*IdxW+3] = is_init ? n_eff :
                                   (do_remove ? live_total - CntW'(1) :
                                   (do_insert ? live_total + CntW'(1) : live_total));
    pack[PackW-1:3*IdxW+CntW+3] = (is_init || id_inc >= n_eff) ? '0 : IdxW'(id_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_init <= 1'b0;
      live_total <= '0;
      cursor <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        is_init <= 1'b0;
      end
      if (cmd.phase == PH_FILL) begin
        is_init <= 1'b1;
      end
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
        live_total <= pack[3*IdxW+CntW+2:3*IdxW+3];
        cursor <= CntW'(pack[PackW-1:3*IdxW+CntW+3]);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= OutW'(pack);
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_total <= CntW'(MaxTriangles)) else $error("live count above table size");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(m_tvalid && !m_tready)) else $error("result overwritten");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid) else $error("committed result not presented");

endmodule
`default_nettype wire

@@ hdl/distance_cull_compact_table.sv @@
`default_nettype none
// Channel  Direction  Handshake            Contents
// s        in         s_tvalid/s_tready    tdata: center_x, center_y, center_z; tuser: cmd
// m        out        m_tvalid/m_tready    tdata: id, action, copy, slot, source, count, next
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A cull step steps from its beat on s through X, Y, Z, ADD, REM and FIN: one shared
// squaring multiplier runs five products while the two map memories are read in turn.
// An init beat sweeps both maps, one entry a cycle, over as many entries as the triangle count.
// Reset clears the live count, the cursor, the viewer and distance registers, not the maps.
// A result waits in the output register while the next beat is taken on s.
module distance_cull_compact_table #(
  parameter int MaxTriangles = dcct_pkg::MaxTrianglesDefault,
  parameter int CoordWidth   = dcct_pkg::CoordWidthDefault,
  parameter int InW          = ((3 * CoordWidth + 7) / 8) * 8,
  parameter int IdxW         = (MaxTriangles > 1) ? $clog2(MaxTriangles) : 1,
  parameter int CntW         = $clog2(MaxTriangles + 1),
  parameter int OutW         = ((4 * IdxW + 3 + CntW + 7) / 8) * 8,
  parameter int CfgW         = (CoordWidth > CntW) ?
                               ((CoordWidth > dcct_pkg::DistW) ? CoordWidth : dcct_pkg::DistW) :
                               ((CntW > dcct_pkg::DistW) ? CntW : dcct_pkg::DistW)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [InW-1:0]                s_tdata,   // center_x, center_y, center_z
  input  wire logic                          s_tuser,   // cmd
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // examined_id, action, copy_valid, copy_slot, copy_source, live_count, next_id
  output logic      [OutW-1:0]               m_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dcct_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgW-1:0]               cfg_data
);
  import dcct_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dcct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .status(status), .cmd(cmd)
  );

  dcct_dp #(
    .MaxTriangles(MaxTriangles), .CoordWidth(CoordWidth), .InW(InW),
    .IdxW(IdxW), .CntW(CntW), .OutW(OutW), .CfgW(CfgW)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

endmodule
`default_nettype wire
